[src/hrn_pkg.sv]
// Package for the Harris response / non-max suppression block.
// Holds geometry limits, field widths, register codes and the shared types.
// No dependencies.
package hrn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IN_W   = 16;
  localparam int K_W    = 16;
  localparam int DIM_W  = 11;
  localparam int RESP_W = 33;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [K_W-1:0]   K_RESET      = K_W'(3932);
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef enum logic [1:0] {
    REG_K      = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } back_state_t;

  // Active configuration, geometry already clamped and given as last index.
  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
  } cfg_t;

  typedef struct packed {
    logic                     flush;
    logic signed [RESP_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     frame_end;
  } result_t;

endpackage

[src/harris_response_nms.sv]
// Harris corner response with 4-neighbor non-max suppression over a raster
// stream. Each pixel goes through a 3-stage multiply pipeline into a 4-entry
// queue; the back end then handles one item at a time (row buffer read, then
// write and result) and takes no new item before it is through with the last,
// as the read and the write on the two 1024-entry row buffers come in turn. A
// flush outside the pending last row is dropped without a row buffer access.
// Results lag the input by one row; after the last row of a frame, send one
// flush per column (or the next frame) to drain it. The row buffers need no
// clearing pass after reset.
module harris_response_nms import hrn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [IN_W-1:0]          sum_xx,
  input  logic [IN_W-1:0]          sum_yy,
  input  logic signed [IN_W-1:0]   sum_xy,
  input  logic                     masked,
  input  logic                     flush,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [RESP_W-1:0] response,
  output logic [COL_W-1:0]         col,
  output logic [ROW_W-1:0]         row,
  output logic                     frame_end,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  hrn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sum_xx  (sum_xx),
    .sum_yy  (sum_yy),
    .sum_xy  (sum_xy),
    .masked  (masked),
    .flush   (flush),
    .k_coeff (cfg.k),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hrn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .response  (response),
    .col       (col),
    .row       (row),
    .frame_end (frame_end)
  );

endmodule

[src/hrn_regs.sv]
// Configuration registers: k coefficient, frame width and frame height.
// Depends on hrn_pkg; clamps the geometry and hands it on as cfg_t.
module hrn_regs import hrn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [K_W-1:0]   k_coeff;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_coeff      <= K_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_K:      k_coeff      <= pwdata[K_W-1:0];
        REG_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_K:      prdata = DATA_W'(k_coeff);
      REG_WIDTH:  prdata = DATA_W'(frame_width);
      REG_HEIGHT: prdata = DATA_W'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // clamp to [3, max] and store as the last index
  always_comb begin
    cfg.k = k_coeff;
    if (frame_width < DIM_W'(3))
      cfg.w_last = COL_W'(2);
    else if (frame_width > DIM_W'(MAX_WIDTH))
      cfg.w_last = COL_W'(MAX_WIDTH - 1);
    else
      cfg.w_last = COL_W'(frame_width - DIM_W'(1));

    if (frame_height < DIM_W'(3))
      cfg.h_last = ROW_W'(2);
    else if (frame_height > DIM_W'(MAX_HEIGHT))
      cfg.h_last = ROW_W'(MAX_HEIGHT - 1);
    else
      cfg.h_last = ROW_W'(frame_height - DIM_W'(1));
  end

endmodule

[src/hrn_front.sv]
// Front end: accepts items, computes the Harris response in a three-stage
// multiply pipeline and queues {flush, value} for the back end. Uses hrn_pkg.
module hrn_front import hrn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [IN_W-1:0]        sum_xx,
  input  logic [IN_W-1:0]        sum_yy,
  input  logic signed [IN_W-1:0] sum_xy,
  input  logic                   masked,
  input  logic                   flush,
  input  logic [K_W-1:0]         k_coeff,
  output logic                   q_valid,
  output item_t                  q_item,
  input  logic                   q_pop
);

  localparam int PROD_W  = 2 * IN_W;
  localparam int TR_W    = IN_W + 1;
  localparam int TR2_W   = 2 * TR_W;
  localparam int DET_W   = PROD_W + 2;
  localparam int P_W     = K_W + TR2_W;
  localparam int KT_W    = P_W + 1 - FRAC_BITS;
  localparam int R_W     = KT_W + 1;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);

  logic                     en;
  logic                     accept;
  logic [TR_W-1:0]          tr;

  logic                     v1, v2, v3;
  logic [PROD_W-1:0]        s1_pp;
  logic signed [PROD_W-1:0] s1_qq;
  logic [TR2_W-1:0]         s1_t2;
  logic                     s1_masked, s1_flush;
  logic signed [DET_W-1:0]  s2_det;
  logic [P_W-1:0]           s2_p;
  logic                     s2_masked, s2_flush;
  logic signed [DET_W-1:0]  s3_det;
  logic [KT_W-1:0]          s3_kt;
  logic                     s3_masked, s3_flush;

  logic [P_W:0]             p_round;
  logic signed [R_W-1:0]    r;
  logic signed [RESP_W-1:0] r_sat;
  item_t                    item_in;

  item_t                    q_mem [Q_DEPTH];
  logic [QP_W-1:0]          q_wr, q_rd;
  logic [QP_W:0]            q_count;
  logic                     q_full, q_push;

  // stall the whole pipe when the last stage cannot enter the queue
  assign en     = !(v3 && q_full);
  assign full   = !en;
  assign accept = push && en;
  assign tr     = {1'b0, sum_xx} + {1'b0, sum_yy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pp     <= sum_xx * sum_yy;
      s1_qq     <= sum_xy * sum_xy;
      s1_t2     <= tr * tr;
      s1_masked <= masked;
      s1_flush  <= flush;

      s2_det    <= $signed({2'b00, s1_pp}) - $signed({{2{s1_qq[PROD_W-1]}}, s1_qq});
      s2_p      <= k_coeff * s1_t2;
      s2_masked <= s1_masked;
      s2_flush  <= s1_flush;

      s3_det    <= s2_det;
      s3_kt     <= p_round[P_W:FRAC_BITS];
      s3_masked <= s2_masked;
      s3_flush  <= s2_flush;
    end
  end

  // round k*tr^2 to nearest, ties upward
  assign p_round = {1'b0, s2_p} + ((P_W + 1)'(1) << (FRAC_BITS - 1));

  always_comb begin
    r = $signed({{(R_W - DET_W){s3_det[DET_W-1]}}, s3_det}) - $signed({1'b0, s3_kt});
    if (&r[R_W-1:RESP_W-1] || ~|r[R_W-1:RESP_W-1])
      r_sat = r[RESP_W-1:0];
    else
      r_sat = {r[R_W-1], {(RESP_W - 1){~r[R_W-1]}}};
    item_in.flush = s3_flush;
    item_in.value = s3_masked ? '0 : r_sat;
  end

  assign q_full  = q_count == (QP_W + 1)'(Q_DEPTH);
  assign q_push  = v3 && !q_full;
  assign q_valid = q_count != '0;
  assign q_item  = q_mem[q_rd];

  always_ff @(posedge clk) begin
    if (q_push)
      q_mem[q_wr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push)
        q_wr <= q_wr + QP_W'(1);
      if (q_pop)
        q_rd <= q_rd + QP_W'(1);
      if (q_push && !q_pop)
        q_count <= q_count + (QP_W + 1)'(1);
      else if (!q_push && q_pop)
        q_count <= q_count - (QP_W + 1)'(1);
    end
  end

endmodule

[src/hrn_back.sv]
// Back end: row buffers, position tracking, 4-neighbor suppression and the
// result queue. Uses hrn_pkg; takes items from the queue in hrn_front.
module hrn_back import hrn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [RESP_W-1:0] response,
  output logic [COL_W-1:0]         col,
  output logic [ROW_W-1:0]         row,
  output logic                     frame_end
);

  localparam int O_DEPTH = 2;
  localparam int OP_W    = $clog2(O_DEPTH);

  back_state_t state, state_next;

  logic signed [RESP_W-1:0] row_above  [MAX_WIDTH];
  logic signed [RESP_W-1:0] row_center [MAX_WIDTH];

  logic [COL_W-1:0]         in_col;
  logic [ROW_W:0]           in_row;
  logic signed [RESP_W-1:0] left_value;
  item_t                    cur;
  logic signed [RESP_W-1:0] center, right, above;

  logic [COL_W-1:0]         col_right;
  logic                     pending, row_end, interior, lower;
  logic                     out_room, start, drop;
  logic                     rd_en, wr_en, emit;
  result_t                  res;

  result_t                  out_mem [O_DEPTH];
  logic [OP_W-1:0]          o_wr, o_rd;
  logic [OP_W:0]            o_count;
  logic                     o_pop;

  assign pending   = in_row > {1'b0, cfg.h_last};
  assign row_end   = in_col >= cfg.w_last;
  assign col_right = in_col + COL_W'(1);
  assign out_room  = o_count != (OP_W + 1)'(O_DEPTH);
  assign start     = q_valid && out_room;
  // a flush outside the pending last row does nothing
  assign drop      = q_item.flush && !pending;

  always_ff @(posedge clk) begin
    if (rst)
      state <= B_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (start && !drop) state_next = B_EXEC;
      B_EXEC: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    emit  = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_pop = start;
        rd_en = start && !drop;
      end
      B_EXEC: begin
        wr_en = !cur.flush;
        emit  = pending || (in_row != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur    <= q_item;
      center <= row_center[in_col];
      right  <= row_center[col_right];
      above  <= row_above[in_col];
    end
    if (wr_en) begin
      row_center[in_col] <= cur.value;
      row_above[in_col]  <= center;
    end
  end

  assign interior = (in_row >= (ROW_W + 1)'(2)) && (in_col != '0) && !row_end;
  assign lower    = (center < right) || (center < left_value) ||
                    (center < cur.value) || (center < above);

  always_comb begin
    res.col = in_col;
    if (pending) begin
      res.response  = center;
      res.row       = cfg.h_last;
      res.frame_end = row_end;
    end else begin
      res.response  = (interior && lower) ? '0 : center;
      res.row       = in_row[ROW_W-1:0] - ROW_W'(1);
      res.frame_end = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      left_value <= '0;
    end else if (state == B_EXEC) begin
      if (wr_en)
        left_value <= center;
      if (row_end) begin
        in_col <= '0;
        if (pending)
          in_row <= cur.flush ? '0 : (ROW_W + 1)'(1);
        else
          in_row <= in_row + (ROW_W + 1)'(1);
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

  // result queue
  assign o_pop     = pop && !empty;
  assign empty     = o_count == '0;
  assign response  = out_mem[o_rd].response;
  assign col       = out_mem[o_rd].col;
  assign row       = out_mem[o_rd].row;
  assign frame_end = out_mem[o_rd].frame_end;

  always_ff @(posedge clk) begin
    if (emit)
      out_mem[o_wr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (emit)
        o_wr <= o_wr + OP_W'(1);
      if (o_pop)
        o_rd <= o_rd + OP_W'(1);
      if (emit && !o_pop)
        o_count <= o_count + (OP_W + 1)'(1);
      else if (!emit && o_pop)
        o_count <= o_count - (OP_W + 1)'(1);
    end
  end

endmodule

[src/hrn_checker.sv]
// Port-level checks for harris_response_nms, attached by bind.
// Depends on hrn_pkg for field widths.
module hrn_checker import hrn_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     push,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic signed [RESP_W-1:0] response,
  input logic [COL_W-1:0]         col,
  input logic [ROW_W-1:0]         row,
  input logic                     frame_end
);

  // reset leaves no result waiting and the input open
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  // a waiting result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(response) && $stable(col) &&
                       $stable(row) && $stable(frame_end))
    else $error("waiting result changed before transfer");

  // frame end sits on the bottom right pixel, so with at least a 3x3 frame it lies at column and row 2 or beyond
  a_frame_end_pos: assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> col >= COL_W'(2) && row >= ROW_W'(2))
    else $error("frame end reported inside the frame");

  // with no result waiting the back end frees a queue slot and the input stall ends
  a_full_releases: assert property (@(posedge clk) disable iff (rst)
    full && empty |-> ##[1:2] !full)
    else $error("input stalled with nothing waiting at the output");

endmodule

bind harris_response_nms hrn_checker u_checker (.*);
